FILE: hdl/lphs_pkg.sv
// Package for the linear probe hash set: command, status and slot state codes,
// port field widths and the load limit reset value. No dependencies.
package lphs_pkg;

  // port field widths
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 32;
  localparam int HASH_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 10;
  localparam int ENTRIES_W = 11;
  localparam int LIMIT_W   = 10;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 10'd816;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] RES_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] RES_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] RES_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] RES_ABSENT   = 3'd3;
  localparam logic [STATUS_W-1:0] RES_FULL     = 3'd4;

  // slot state stored next to each key
  localparam int SST_W = 2;
  localparam logic [SST_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SST_W-1:0] SLOT_LIVE  = 2'd1;
  localparam logic [SST_W-1:0] SLOT_GRAVE = 2'd2;

endpackage

FILE: hdl/lphs_table.sv
// Slot table memory for the linear probe hash set: one write port and one
// read port with registered read data. No dependencies.
module lphs_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/linear_probe_hash_set.sv
// Top level of the linear probe hash set: probe sequencer, counters, result
// register and load limit register. Uses lphs_pkg and lphs_table.
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  ------------------------------
// in       to block   in_valid / in_ready    cmd, key, key_hash
// out      from block out_valid / out_ready  status, slot, entries
// cfg      to block   cfg_valid / cfg_ready  cfg_data (load_limit)
//
// Each item passes through accept, hash reduction, first read, probe and finish;
// the probe evaluates one slot per cycle through the table read port, and the
// hash reduction has 3 steps (reciprocal multiply, multiply back and subtract,
// one correction) when TABLE_SLOTS is not a power of two, none otherwise. Full
// inserts and unknown commands go from accept straight to finish.
// Reset starts a clearing pass that empties every slot; in_ready stays low
// meanwhile, cfg transfers are taken at all times.
// A new item is taken while a result still waits on out; the finish step
// stalls only if the result register is still occupied.
module linear_probe_hash_set #(
  parameter int TABLE_SLOTS = 1024,
  parameter int KEY_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lphs_pkg::CMD_W-1:0]      cmd,
  input  logic [lphs_pkg::KEY_W-1:0]      key,
  input  logic [lphs_pkg::HASH_W-1:0]     key_hash,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lphs_pkg::STATUS_W-1:0]   status,
  output logic [lphs_pkg::SLOT_W-1:0]     slot,
  output logic [lphs_pkg::ENTRIES_W-1:0]  entries,
  // load limit write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lphs_pkg::LIMIT_W-1:0]    cfg_data
);

  import lphs_pkg::*;

  localparam int  IDX_W    = $clog2(TABLE_SLOTS);
  localparam int  CNT_W    = $clog2(TABLE_SLOTS + 1);
  localparam int  SUM_W    = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
  localparam int  ENT_W    = SST_W + KEY_BITS;
  localparam bit  IS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  // floor(2^32 / TABLE_SLOTS): quotient estimate is exact or one low
  localparam logic [63:0]       RECIP_L  = 64'h1_0000_0000 / 64'(TABLE_SLOTS);
  localparam logic [HASH_W-1:0] RECIP    = HASH_W'(RECIP_L);
  localparam logic [HASH_W-1:0] SLOTS_H  = HASH_W'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HMOD, S_READ, S_EVAL, S_FINISH
  } state_t;

  state_t              state;

  // item registers
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic                full_r;
  logic                found;
  logic                where_v;
  logic                grave_v;
  logic [IDX_W-1:0]    grave_idx;
  logic [IDX_W-1:0]    idx;        // probe position, also clear sweep address
  logic [IDX_W-1:0]    probes;

  // hash reduction by reciprocal multiply, one shared multiplier
  logic [HASH_W-1:0]   hsh;
  logic [1:0]          hstep;
  logic [HASH_W-1:0]   quot;
  logic [HASH_W-1:0]   rem_raw;
  logic [HASH_W-1:0]   rem_fix;
  logic [HASH_W-1:0]   mul_a;
  logic [HASH_W-1:0]   mul_b;
  logic [2*HASH_W-1:0] mul_p;

  // table occupancy
  logic [CNT_W-1:0]    live;
  logic [CNT_W-1:0]    grave;
  logic [LIMIT_W-1:0]  load_limit;
  logic                at_limit;

  // table port
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENT_W-1:0]    mem_rdata;
  logic [SST_W-1:0]    rd_state;
  logic [KEY_BITS-1:0] rd_key;

  // finish step
  logic [STATUS_W-1:0] fin_status;
  logic [IDX_W-1:0]    fin_slot;
  logic                fin_we;
  logic [SST_W-1:0]    fin_wstate;
  logic [IDX_W-1:0]    fin_waddr;
  logic [CNT_W-1:0]    live_next;
  logic [CNT_W-1:0]    grave_next;

  logic [IDX_W-1:0]    idx_inc;
  logic                out_free;
  logic                cmd_known;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign at_limit  = (SUM_W'(live) + SUM_W'(grave)) >= SUM_W'(load_limit);
  assign cmd_known = (cmd == CMD_INSERT) || (cmd == CMD_CONTAINS) || (cmd == CMD_REMOVE);

  // step 0: hash * reciprocal, step 1: quotient * slots
  assign mul_a   = (hstep == 2'd0) ? hsh : quot;
  assign mul_b   = (hstep == 2'd0) ? RECIP : SLOTS_H;
  assign mul_p   = mul_a * mul_b;
  // raw remainder lies below twice the slot count
  assign rem_fix = (rem_raw >= SLOTS_H) ? rem_raw - SLOTS_H : rem_raw;

  assign rd_state = mem_rdata[ENT_W-1 -: SST_W];
  assign rd_key   = mem_rdata[KEY_BITS-1:0];

  // read ahead: while evaluating a slot, the next one is fetched
  assign mem_raddr = (state == S_EVAL) ? idx_inc : idx;

  // finish decisions
  always_comb begin
    fin_status = RES_ABSENT;
    fin_slot   = '0;
    fin_we     = 1'b0;
    fin_wstate = SLOT_LIVE;
    fin_waddr  = idx;
    live_next  = live;
    grave_next = grave;
    unique case (cmd_r)
      CMD_INSERT: begin
        priority if (full_r) begin
          fin_status = RES_FULL;
        end else if (found) begin
          fin_status = RES_PRESENT;
          fin_slot   = idx;
        end else if (grave_v) begin
          // reuse the first tombstone passed
          fin_status = RES_INSERTED;
          fin_slot   = grave_idx;
          fin_we     = 1'b1;
          fin_waddr  = grave_idx;
          live_next  = live + 1'b1;
          grave_next = grave - 1'b1;
        end else if (where_v) begin
          fin_status = RES_INSERTED;
          fin_slot   = idx;
          fin_we     = 1'b1;
          live_next  = live + 1'b1;
        end else begin
          fin_status = RES_FULL;
        end
      end
      CMD_CONTAINS: begin
        if (found) begin
          fin_status = RES_PRESENT;
          fin_slot   = idx;
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          fin_status = RES_REMOVED;
          fin_slot   = idx;
          fin_we     = 1'b1;
          fin_wstate = SLOT_GRAVE;
          live_next  = live - 1'b1;
          grave_next = grave + 1'b1;
        end
      end
      default: begin
        fin_status = RES_ABSENT;
      end
    endcase
  end

  // table write port: clear sweep or finish update
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = {SLOT_EMPTY, {KEY_BITS{1'b0}}};
    end else begin
      mem_we    = (state == S_FINISH) && fin_we && out_free;
      mem_waddr = fin_waddr;
      mem_wdata = {fin_wstate, key_r};
    end
  end

  lphs_table #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      out_valid  <= 1'b0;
      live       <= '0;
      grave      <= '0;
      load_limit <= LOAD_LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        load_limit <= cfg_data;
      end
      // the finish step reloads the result register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd;
            key_r   <= KEY_BITS'(key);
            full_r  <= (cmd == CMD_INSERT) && at_limit;
            found   <= 1'b0;
            where_v <= 1'b0;
            grave_v <= 1'b0;
            probes  <= '0;
            hsh     <= key_hash;
            hstep   <= '0;
            idx     <= IS_POW2 ? key_hash[IDX_W-1:0] : '0;
            // full inserts and unknown commands skip the probe
            if (!cmd_known || ((cmd == CMD_INSERT) && at_limit)) begin
              state <= S_FINISH;
            end else if (IS_POW2) begin
              state <= S_READ;
            end else begin
              state <= S_HMOD;
            end
          end
        end
        S_HMOD: begin
          unique case (hstep)
            2'd0: begin
              quot  <= mul_p[2*HASH_W-1:HASH_W];
              hstep <= 2'd1;
            end
            2'd1: begin
              rem_raw <= hsh - mul_p[HASH_W-1:0];
              hstep   <= 2'd2;
            end
            default: begin
              idx   <= IDX_W'(rem_fix);
              state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          priority if (rd_state == SLOT_EMPTY) begin
            where_v <= 1'b1;
            state   <= S_FINISH;
          end else if ((rd_state == SLOT_LIVE) && (rd_key == key_r)) begin
            found <= 1'b1;
            state <= S_FINISH;
          end else begin
            if ((rd_state == SLOT_GRAVE) && !grave_v) begin
              grave_v   <= 1'b1;
              grave_idx <= idx;
            end
            // whole table walked without an empty slot
            if (probes == LAST_IDX) begin
              state <= S_FINISH;
            end else begin
              idx    <= idx_inc;
              probes <= probes + 1'b1;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= fin_status;
            slot      <= SLOT_W'(fin_slot);
            entries   <= ENTRIES_W'(live_next);
            live      <= live_next;
            grave     <= grave_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: bench/lphs_checker.sv
`timescale 1ns / 100ps
// Checker for the linear probe hash set: watches the item, result and load limit
// channels, keeps its own copy of the table and compares every result. Uses lphs_pkg.
module lphs_checker #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [lphs_pkg::CMD_W-1:0]     cmd,
  input  logic [lphs_pkg::KEY_W-1:0]     key,
  input  logic [lphs_pkg::HASH_W-1:0]    key_hash,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [lphs_pkg::STATUS_W-1:0]  status,
  input  logic [lphs_pkg::SLOT_W-1:0]    slot,
  input  logic [lphs_pkg::ENTRIES_W-1:0] entries,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lphs_pkg::LIMIT_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked,
  output int                             full_seen,
  output int                             graves_reused,
  output int                             longest_probe
);

  import lphs_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [ENTRIES_W-1:0] entries;
  } set_outcome_t;

  // shadow table
  logic [SST_W-1:0] tbl_state [TABLE_SLOTS];
  logic [KEY_W-1:0] tbl_key   [TABLE_SLOTS];
  int               live_n;
  int               grave_n;
  logic [LIMIT_W-1:0] limit_r;

  set_outcome_t due_outcomes[$];

  // Walk forward from the home slot until an empty slot, a live match or a full lap of the table.
  function automatic void walk_chain(input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h,
                                     output bit hit, output int where,
                                     output int first_grave, output int steps);
    int idx;
    idx = int'(h % 32'(TABLE_SLOTS));
    hit = 1'b0;
    where = -1;
    first_grave = -1;
    steps = 0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      steps = n + 1;
      if (tbl_state[idx] == SLOT_EMPTY) begin
        where = idx;
        return;
      end
      if (tbl_state[idx] == SLOT_LIVE && tbl_key[idx] == k) begin
        hit = 1'b1;
        where = idx;
        return;
      end
      if (tbl_state[idx] == SLOT_GRAVE && first_grave < 0) first_grave = idx;
      idx = (idx + 1) % TABLE_SLOTS;
    end
  endfunction

  task automatic run_set_op(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                            input logic [HASH_W-1:0] h, output set_outcome_t res);
    bit hit;
    int where;
    int grave;
    int steps;
    int target;
    hit = 1'b0;
    steps = 0;
    res.status = RES_ABSENT;
    res.slot = '0;
    case (c)
      CMD_INSERT: begin
        // load check comes before the probe, so a present key can still be refused
        if (live_n + grave_n >= int'(limit_r)) begin
          res.status = RES_FULL;
        end else begin
          walk_chain(k, h, hit, where, grave, steps);
          if (hit) begin
            res.status = RES_PRESENT;
            res.slot = SLOT_W'(where);
          end else begin
            target = (grave >= 0) ? grave : where;
            if (target < 0) begin
              res.status = RES_FULL;
            end else begin
              if (grave >= 0) begin
                grave_n--;
                graves_reused++;
              end
              live_n++;
              tbl_key[target] = k;
              tbl_state[target] = SLOT_LIVE;
              res.status = RES_INSERTED;
              res.slot = SLOT_W'(target);
            end
          end
        end
      end
      CMD_CONTAINS: begin
        walk_chain(k, h, hit, where, grave, steps);
        if (hit) begin
          res.status = RES_PRESENT;
          res.slot = SLOT_W'(where);
        end
      end
      CMD_REMOVE: begin
        walk_chain(k, h, hit, where, grave, steps);
        if (hit) begin
          tbl_state[where] = SLOT_GRAVE;
          grave_n++;
          live_n--;
          res.status = RES_REMOVED;
          res.slot = SLOT_W'(where);
        end
      end
      default: ;
    endcase
    res.entries = ENTRIES_W'(live_n);
    if (res.status == RES_FULL) full_seen++;
    if (steps > longest_probe) longest_probe = steps;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    checked = 0;
    full_seen = 0;
    graves_reused = 0;
    longest_probe = 0;
  end

  always @(posedge clk) begin
    set_outcome_t want;
    set_outcome_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tbl_state[i] = SLOT_EMPTY;
        tbl_key[i] = '0;
      end
      live_n = 0;
      grave_n = 0;
      limit_r = LOAD_LIMIT_RESET;
      due_outcomes.delete();
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        checked++;
        got.status = status;
        got.slot = slot;
        got.entries = entries;
        if (due_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: status %0d slot %0d entries %0d",
                   $time, got.status, got.slot, got.entries);
        end else begin
          want = due_outcomes.pop_front();
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
          if (got.slot !== want.slot) begin
            mismatches++;
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, got.slot);
          end
          if (got.entries !== want.entries) begin
            mismatches++;
            $display("%0t: entries mismatch, expected %0d, actual %0d",
                     $time, want.entries, got.entries);
          end
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) limit_r = cfg_data;
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        run_set_op(cmd, key, key_hash, want);
        due_outcomes.push_back(want);
      end
    end
    outstanding = due_outcomes.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the hash set bench: clock, reset, stimulus, load limit phases and verdict.
// Depends on lphs_pkg, linear_probe_hash_set and lphs_checker.
module testbench;
  import lphs_pkg::*;

  localparam int TABLE_SLOTS = 1024;
  // a probe walks at most the whole table; this leaves many times that plus stalls
  localparam int STALL_LIMIT = 20000;
  localparam int POOL_N      = 48;
  localparam int CLUSTERS    = 6;
  // the command code the block must answer as absent without touching the table
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd;
  logic [KEY_W-1:0]     key;
  logic [HASH_W-1:0]    key_hash;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot;
  logic [ENTRIES_W-1:0] entries;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  int mismatches;
  int outstanding;
  int checked;
  int full_seen;
  int graves_reused;
  int longest_probe;

  // stimulus bookkeeping
  bit calm;            // set: neither side idles
  int items_sent;
  int limit_writes;
  int quiet;

  // key pool: keys whose home slots sit in a few tight clusters, one of them
  // straddling the end of the table, so chains, tombstones and wrap-around form
  logic [KEY_W-1:0]  pool_key [POOL_N];
  logic [SLOT_W-1:0] pool_home[POOL_N];

  linear_probe_hash_set #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BITS   (KEY_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .key      (key),
    .key_hash (key_hash),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .slot     (slot),
    .entries  (entries),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  lphs_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .key          (key),
    .key_hash     (key_hash),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .entries      (entries),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked),
    .full_seen    (full_seen),
    .graves_reused(graves_reused),
    .longest_probe(longest_probe)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side back-pressure: ready drops about 30% of cycles unless calm.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 30);
  end

  // Watchdog: any cycle with a transfer on some channel restarts the count.
  // The clearing pass after reset (one slot per cycle) fits well inside it.
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1 ||
          (cfg_valid && cfg_ready) === 1'b1)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $time, quiet, outstanding);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // One item transfer. Called and returns at a falling edge; valid stays up
  // after the transfer so that back-to-back items keep it high.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [HASH_W-1:0] h);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    key      <= k;
    key_hash <= h;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // Load limit write; only issued with nothing in flight.
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // Stop sending and wait for every due result. Every item yields a result,
  // so once nothing is due the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_op();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CMD_INSERT;
      4, 5, 6:    return CMD_CONTAINS;
      default:    return CMD_REMOVE;
    endcase
  endfunction

  // One load limit setting and a batch of random items under it.
  // Mix: 80% pool traffic, 12% stray keys or pool keys with foreign hashes,
  // the rest the unknown command.
  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n, input bit no_idle);
    int r;
    int p;
    logic [CMD_W-1:0]  c;
    logic [KEY_W-1:0]  k;
    logic [HASH_W-1:0] h;
    drain();
    write_limit(lim);
    calm = no_idle;
    repeat (n) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL_N - 1);
      k = pool_key[p];
      // upper hash bits vary freely; only the home slot matters
      h = $urandom;
      h[SLOT_W-1:0] = pool_home[p];
      if (r < 80) begin
        c = pick_op();
      end else if (r < 92) begin
        c = pick_op();
        if ($urandom_range(0, 1) == 1) k = $urandom;
        h = $urandom;
      end else begin
        c = CMD_UNKNOWN;
        k = $urandom;
        h = $urandom;
      end
      send_item(c, k, h);
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [SLOT_W-1:0] base [CLUSTERS];
    in_valid   = 1'b0;
    cmd        = CMD_INSERT;
    key        = '0;
    key_hash   = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    calm       = 1'b0;
    items_sent = 0;
    limit_writes = 0;
    rst        = 1'b1;

    base[0] = SLOT_W'(TABLE_SLOTS - 4);
    for (int j = 1; j < CLUSTERS; j++) base[j] = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    for (int i = 0; i < POOL_N; i++) begin
      pool_key[i]  = $urandom;
      pool_home[i] = base[i % CLUSTERS] + SLOT_W'($urandom_range(0, 5));
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part under a small limit, from an empty table.
    write_limit(10'd8);
    send_item(CMD_INSERT,   32'hA5A5_0001, 32'hFFFF_FFFF);  // last slot
    send_item(CMD_INSERT,   32'hA5A5_0002, 32'h0000_03FF);  // wraps to slot 0
    send_item(CMD_INSERT,   32'hA5A5_0003, 32'h7FFF_FFFF);  // slot 1
    send_item(CMD_INSERT,   32'hA5A5_0002, 32'h0000_03FF);  // duplicate
    send_item(CMD_CONTAINS, 32'hA5A5_0003, 32'hFFFF_FBFF);
    send_item(CMD_REMOVE,   32'hA5A5_0002, 32'h0000_03FF);  // leaves a tombstone
    send_item(CMD_CONTAINS, 32'hA5A5_0003, 32'h0000_03FF);  // walks past it
    send_item(CMD_INSERT,   32'hA5A5_0004, 32'h0000_03FF);  // reuses the tombstone
    send_item(CMD_REMOVE,   32'hA5A5_0004, 32'h0000_03FF);
    send_item(CMD_REMOVE,   32'hA5A5_0004, 32'h0000_03FF);  // already gone
    send_item(CMD_CONTAINS, 32'hA5A5_0002, 32'h0000_03FF);  // absent
    send_item(CMD_UNKNOWN,  32'hA5A5_0003, 32'h0000_03FF);
    send_item(CMD_INSERT,   32'h0000_0000, 32'h0000_0000);
    send_item(CMD_INSERT,   32'hFFFF_FFFF, 32'h0000_0400);
    send_item(CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_REMOVE,   32'h0000_0000, 32'h0000_0000);
    send_item(CMD_INSERT,   32'h1111_1111, 32'h0000_0005);
    send_item(CMD_INSERT,   32'h2222_2222, 32'h0000_0005);
    send_item(CMD_INSERT,   32'h3333_3333, 32'h0000_0005);
    send_item(CMD_INSERT,   32'h4444_4444, 32'h0000_0005);
    send_item(CMD_INSERT,   32'h5555_5555, 32'h0000_0005);  // limit reached
    send_item(CMD_INSERT,   32'hA5A5_0001, 32'hFFFF_FFFF);  // present, still full
    send_item(CMD_CONTAINS, 32'h4444_4444, 32'h0000_0005);
    send_item(CMD_REMOVE,   32'h2222_2222, 32'h0000_0005);
    send_item(CMD_CONTAINS, 32'h3333_3333, 32'hFFFF_FC05);

    // Random phases; each begins with the sender holding off until idle.
    run_phase(10'd1023, 300, 1'b0);
    run_phase(10'd64,   200, 1'b0);   // occupancy hovers near the limit
    run_phase(LOAD_LIMIT_RESET, 200, 1'b1);  // no idling on either side
    run_phase(LIMIT_W'($urandom_range(2, 1022)), 200, 1'b0);
    run_phase(10'd0,    20,  1'b0);   // every insert refused
    run_phase(10'd1,    10,  1'b0);

    drain();
    repeat (64) @(negedge clk);

    $display("Sent %0d items over %0d load limit settings (0 through 1023); %0d results checked.",
             items_sent, limit_writes, checked);
    $display("Full answers %0d, tombstones reused %0d, longest probe %0d slots, mismatches %0d.",
             full_seen, graves_reused, longest_probe, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
